>>> rtl/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step sequencer package
// Request codes, configuration register indexes, reset values and the
// layout of one pattern cell.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int unsigned SpsW    = 24;
  localparam int unsigned SwingW  = 8;
  localparam int unsigned LenW    = 7;
  localparam int unsigned GainW   = 10;
  localparam int unsigned CountW  = 14;
  localparam int unsigned CellW   = 6;
  localparam int unsigned NoteW   = 7;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned ThrW    = 25;
  localparam int unsigned SwOffW  = 23;

  localparam logic [SpsW-1:0]   SpsReset   = 24'd5512;
  localparam logic [SwingW-1:0] SwingReset = 8'd0;
  localparam logic [LenW-1:0]   LenReset   = 7'd16;
  localparam logic              LoopReset  = 1'b1;
  localparam logic [GainW-1:0]  GainReset  = 10'd256;
  localparam logic [GainW-1:0]  GainMax    = 10'd512;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_RECORD = 3'd3,
    REQ_CELL   = 3'd4
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPS   = 3'd0,
    CFG_SWING = 3'd1,
    CFG_LEN   = 3'd2,
    CFG_LOOP  = 3'd3,
    CFG_GAIN  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             active;
    logic [NoteW-1:0] pitch;
    logic [NoteW-1:0] velocity;
  } cell_t;

endpackage

>>> rtl/ssq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data that holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module ssq_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/swing_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing step sequencer
// Transport for a step pattern: ticks advance a sample position through
// steps with swing on odd steps, active steps fire notes.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_* valid/ready channel and every item gives
// exactly one result item on the out_* valid/ready channel, in order.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i with no handshake; they should only change while the block
// is idle.
// An accepted item sits in the input register, the execute stage then
// updates the transport state and reads the pattern memory into the note
// stage, and the output register then takes the scaled velocity and status.
// One item is accepted every cycle unless the receiver stalls or the sweep
// after reset is running; the throughput is set by the execute stage.
// After reset the pattern memory is swept to zero, one entry per cycle, so
// in_ready_o stays low until every entry is cleared; configuration writes
// are taken during that sweep. When the receiver stalls, results fill the
// output, note and input registers and then in_ready_o drops; nothing is
// lost.
// ----------------------------------------------------------------------------
module swing_step_sequencer
  import ssq_pkg::*;
#(
  parameter int unsigned STEP_DEPTH     = 64,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic [CountW-1:0]  sample_count_i,
  input  logic [CellW-1:0]   cell_index_i,
  input  logic [NoteW-1:0]   pitch_i,
  input  logic [NoteW-1:0]   velocity_i,
  input  logic               cell_active_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               note_start_o,
  output logic [NoteW-1:0]   note_pitch_o,
  output logic [LevelW-1:0]  note_level_o,
  output logic               release_all_o,
  output logic [CellW-1:0]   step_now_o,
  output logic               step_valid_o,
  output logic               is_playing_o,
  output logic               reached_end_o
);

  // Address width of the pattern memory and a compare width that holds
  // both the step count plus one and the seven-bit pattern length.
  localparam int unsigned AW = $clog2(STEP_DEPTH);
  localparam int unsigned CW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned EW = (PW > ThrW) ? PW : ThrW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SpsW-1:0]   sps_q;
  logic [SwingW-1:0] swing_q;
  logic [LenW-1:0]   len_q;
  logic              loop_q;
  logic [GainW-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q   <= SpsReset;
      swing_q <= SwingReset;
      len_q   <= LenReset;
      loop_q  <= LoopReset;
      gain_q  <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SPS:   sps_q   <= cfg_wdata_i[SpsW-1:0];
        CFG_SWING: swing_q <= cfg_wdata_i[SwingW-1:0];
        CFG_LEN:   len_q   <= cfg_wdata_i[LenW-1:0];
        CFG_LOOP:  loop_q  <= cfg_wdata_i[0];
        CFG_GAIN:  gain_q  <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // A zero step length counts as one sample.
  logic [SpsW-1:0] sps_eff;
  assign sps_eff = (sps_q == '0) ? SpsW'(1) : sps_q;

  // The swing offset depends on configuration only, so it is computed into a
  // register of its own and is settled before the next item executes.
  logic [31:0]       swing_prod;
  logic [SwOffW-1:0] swing_off_q;
  assign swing_prod = 32'(swing_q) * 32'(sps_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_off_q <= '0;
    end else begin
      swing_off_q <= swing_prod[31:9];
    end
  end

  // The pattern length is clamped to 1 .. STEP_DEPTH.
  logic [CW-1:0] len_ext;
  logic [CW-1:0] eff_len;
  assign len_ext = CW'(len_q);
  always_comb begin
    eff_len = len_ext;
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > CW'(STEP_DEPTH)) begin
      eff_len = CW'(STEP_DEPTH);
    end
  end

  // The velocity gain saturates at two.
  logic [GainW-1:0] gain_eff;
  assign gain_eff = (gain_q > GainMax) ? GainMax : gain_q;

  // --------------------------------------------------------------------------
  // Pipeline control: input register, execute stage, output register.
  // Each stage loads when it is empty or when its contents move on.
  // --------------------------------------------------------------------------
  logic clr_busy_q;
  logic v1_q, v2_q, v3_q;
  logic accept, exec, load3;

  assign load3      = v2_q && (!v3_q || out_ready_i);
  assign exec       = v1_q && (!v2_q || load3);
  assign in_ready_o = !clr_busy_q && (!v1_q || exec);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (exec) begin
        v1_q <= 1'b0;
      end
      if (exec) begin
        v2_q <= 1'b1;
      end else if (load3) begin
        v2_q <= 1'b0;
      end
      if (load3) begin
        v3_q <= 1'b1;
      end else if (out_ready_i) begin
        v3_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  req_type_e         in_req_q;
  logic [CountW-1:0] in_count_q;
  logic [CellW-1:0]  in_cell_q;
  logic [NoteW-1:0]  in_pitch_q;
  logic [NoteW-1:0]  in_vel_q;
  logic              in_act_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q   <= req_type_e'(req_type_i);
      in_count_q <= sample_count_i;
      in_cell_q  <= cell_index_i;
      in_pitch_q <= pitch_i;
      in_vel_q   <= velocity_i;
      in_act_q   <= cell_active_i;
    end
  end

  // --------------------------------------------------------------------------
  // Transport state and execute stage
  // --------------------------------------------------------------------------
  logic          running_q, running_d;
  logic          have_q, have_d;
  logic [AW-1:0] step_q, step_d;
  logic [PW-1:0] pos_q, pos_d;

  logic [PW:0]     pos_sum;
  logic [PW-1:0]   pos_sat;
  logic [ThrW-1:0] thr;
  logic            thr_hit;
  logic [PW-1:0]   pos_left;
  logic [CW-1:0]   next_step;
  logic            past_end;
  logic [CW-1:0]   cell_ext;

  logic          fire;
  logic          rel;
  logic          at_end;
  logic          ex_we;
  logic [AW-1:0] ex_waddr;
  cell_t         ex_wdata;

  assign pos_sum  = (PW + 1)'(pos_q) + (PW + 1)'(in_count_q);
  assign pos_sat  = pos_sum[PW] ? {PW{1'b1}} : pos_sum[PW-1:0];
  // Odd steps are lengthened by the swing offset, but not before the first
  // step has been entered.
  assign thr      = ThrW'(sps_eff)
                  + ((have_q && step_q[0]) ? ThrW'(swing_off_q) : ThrW'(0));
  assign thr_hit  = EW'(pos_sat) >= EW'(thr);
  assign pos_left = pos_sat - PW'(thr);
  assign next_step = have_q ? (CW'(step_q) + CW'(1)) : '0;
  assign past_end = next_step >= eff_len;
  assign cell_ext = CW'(in_cell_q);

  always_comb begin
    running_d = running_q;
    have_d    = have_q;
    step_d    = step_q;
    pos_d     = pos_q;
    fire      = 1'b0;
    rel       = 1'b0;
    at_end    = 1'b0;
    ex_we     = 1'b0;
    ex_waddr  = step_q;
    ex_wdata  = '{active: 1'b1, pitch: in_pitch_q, velocity: in_vel_q};
    unique case (in_req_q)
      REQ_TICK: begin
        if (running_q) begin
          pos_d = pos_sat;
          if (thr_hit) begin
            if (past_end && !loop_q) begin
              // End of the pattern with looping off: playback stops.
              running_d = 1'b0;
              have_d    = 1'b0;
              step_d    = '0;
              pos_d     = '0;
              rel       = 1'b1;
              at_end    = 1'b1;
            end else begin
              fire   = 1'b1;
              have_d = 1'b1;
              if (past_end) begin
                step_d = '0;
                pos_d  = '0;
              end else begin
                step_d = next_step[AW-1:0];
                pos_d  = pos_left;
              end
            end
          end
        end
      end
      REQ_START: begin
        if (!running_q) begin
          running_d = 1'b1;
          have_d    = 1'b0;
          step_d    = '0;
          pos_d     = '0;
        end
      end
      REQ_STOP: begin
        if (running_q) begin
          running_d = 1'b0;
          have_d    = 1'b0;
          step_d    = '0;
          pos_d     = '0;
          rel       = 1'b1;
        end
      end
      REQ_RECORD: begin
        ex_we = running_q && have_q && (CW'(step_q) < eff_len);
      end
      REQ_CELL: begin
        ex_we    = cell_ext < CW'(STEP_DEPTH);
        ex_waddr = cell_ext[AW-1:0];
        ex_wdata = '{active: in_act_q, pitch: in_pitch_q, velocity: in_vel_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      have_q    <= 1'b0;
      step_q    <= '0;
      pos_q     <= '0;
    end else if (exec) begin
      running_q <= running_d;
      have_q    <= have_d;
      step_q    <= step_d;
      pos_q     <= pos_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pattern memory with a zeroing sweep after reset
  // --------------------------------------------------------------------------
  logic [AW-1:0] clr_cnt_q;
  logic          clr_last;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cell_t         ram_wdata;
  cell_t         ram_rdata;

  assign clr_last = clr_cnt_q == AW'(STEP_DEPTH - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_last) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_busy_q || (exec && ex_we);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : ex_waddr;
  assign ram_wdata = clr_busy_q ? cell_t'('0) : ex_wdata;

  // An item whose read data is used never writes, and a write lands before
  // any later item reads, so no bypass is needed.
  ssq_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (STEP_DEPTH)
  ) u_pattern (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (exec),
    .raddr_i (step_d),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Note stage register: transport status of the executed item
  // --------------------------------------------------------------------------
  logic             fire_q;
  logic             rel_q;
  logic             end_q;
  logic [CellW-1:0] step_now_q;
  logic             step_valid_q;
  logic             playing_q;
  logic [CW-1:0]    step_ext;

  assign step_ext = CW'(step_d);

  always_ff @(posedge clk_i) begin
    if (exec) begin
      fire_q       <= fire;
      rel_q        <= rel;
      end_q        <= at_end;
      step_now_q   <= have_d ? step_ext[CellW-1:0] : '0;
      step_valid_q <= have_d;
      playing_q    <= running_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: note level from the stored velocity
  // --------------------------------------------------------------------------
  logic        note_on;
  logic [16:0] level_prod;

  assign note_on    = fire_q && ram_rdata.active;
  assign level_prod = 17'(ram_rdata.velocity) * 17'(gain_eff);

  always_ff @(posedge clk_i) begin
    if (load3) begin
      note_start_o  <= note_on;
      note_pitch_o  <= note_on ? ram_rdata.pitch : '0;
      note_level_o  <= note_on ? level_prod[15:8] : '0;
      release_all_o <= rel_q || note_on;
      step_now_o    <= step_now_q;
      step_valid_o  <= step_valid_q;
      is_playing_o  <= playing_q;
      reached_end_o <= end_q;
    end
  end

  assign out_valid_o = v3_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("item accepted during the pattern memory sweep");

  a_end_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reached_end_o) |->
      (release_all_o && !is_playing_o && !step_valid_o && !note_start_o))
    else $error("pattern end result is inconsistent");

  a_note_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && note_start_o) |-> (release_all_o && step_valid_o && is_playing_o))
    else $error("note fired outside a running step");

  a_quiet_when_no_note : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !note_start_o) |-> (note_pitch_o == '0 && note_level_o == '0))
    else $error("note fields set without a note");

endmodule

>>> bench/ssq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing step sequencer checker
// Watches the configuration port and both item channels, keeps its own copy
// of the transport state, the registers and the pattern, and compares every
// result item field by field with the result it predicted.
// ----------------------------------------------------------------------------
module ssq_checker
  import ssq_pkg::*;
#(
  parameter int unsigned STEP_DEPTH     = 64,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         req_type_i,
  input  logic [CountW-1:0]  sample_count_i,
  input  logic [CellW-1:0]   cell_index_i,
  input  logic [NoteW-1:0]   pitch_i,
  input  logic [NoteW-1:0]   velocity_i,
  input  logic               cell_active_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               note_start_i,
  input  logic [NoteW-1:0]   note_pitch_i,
  input  logic [LevelW-1:0]  note_level_i,
  input  logic               release_all_i,
  input  logic [CellW-1:0]   step_now_i,
  input  logic               step_valid_i,
  input  logic               is_playing_i,
  input  logic               reached_end_i,
  output int                 mismatch_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 notes_o,
  output int                 ends_o
);

  typedef struct packed {
    logic              note_start;
    logic [NoteW-1:0]  note_pitch;
    logic [LevelW-1:0] note_level;
    logic              release_all;
    logic [CellW-1:0]  step_now;
    logic              step_valid;
    logic              is_playing;
    logic              reached_end;
  } report_t;

  logic [SpsW-1:0]           sps_q;
  logic [SwingW-1:0]         swing_q;
  logic [LenW-1:0]           len_q;
  logic                      loop_q;
  logic [GainW-1:0]          gain_q;

  logic                      running_q;
  logic                      have_step_q;
  logic [CellW-1:0]          step_q;
  logic [POSITION_WIDTH-1:0] position_q;
  cell_t                     pattern_q [STEP_DEPTH];

  report_t                   due_reports [$];
  report_t                   seen;
  report_t                   want;

  function automatic int unsigned steps_in_use();
    if (len_q == 0) return 1;
    if (len_q > STEP_DEPTH) return STEP_DEPTH;
    return len_q;
  endfunction

  // Updates the transport copy for one item and returns the report it gives.
  task automatic advance_transport(input logic [2:0] req, input logic [CountW-1:0] count,
                                   input logic [CellW-1:0] slot,
                                   input logic [NoteW-1:0] pitch,
                                   input logic [NoteW-1:0] vel, input logic act,
                                   output report_t r);
    logic [SpsW-1:0]         sps;
    logic [ThrW-1:0]         thr;
    logic [31:0]             prod;
    logic [POSITION_WIDTH:0] sum;
    logic [GainW-1:0]        gain;
    int unsigned             next_step;
    cell_t                   c;
    r = '0;
    case (req)
      REQ_TICK: begin
        if (running_q) begin
          sps = (sps_q == 0) ? SpsW'(1) : sps_q;
          thr = ThrW'(sps);
          // Odd steps last longer by the swing share of half a step.
          if (have_step_q && step_q[0]) begin
            prod = 32'(swing_q) * 32'(sps);
            thr  = thr + ThrW'(prod >> 9);
          end
          sum = {1'b0, position_q} + (POSITION_WIDTH + 1)'(count);
          position_q = sum[POSITION_WIDTH] ? '1 : sum[POSITION_WIDTH-1:0];
          if (position_q >= thr) begin
            next_step  = have_step_q ? int'(step_q) + 1 : 0;
            position_q = position_q - thr;
            if (next_step >= steps_in_use()) begin
              if (loop_q) begin
                next_step  = 0;
                position_q = '0;
              end else begin
                running_q     = 1'b0;
                have_step_q   = 1'b0;
                step_q        = '0;
                position_q    = '0;
                r.release_all = 1'b1;
                r.reached_end = 1'b1;
                next_step     = STEP_DEPTH;
              end
            end
            if (next_step < STEP_DEPTH) begin
              c           = pattern_q[next_step];
              step_q      = CellW'(next_step);
              have_step_q = 1'b1;
              if (c.active) begin
                gain          = (gain_q > GainMax) ? GainMax : gain_q;
                prod          = 32'(c.velocity) * 32'(gain);
                r.release_all = 1'b1;
                r.note_start  = 1'b1;
                r.note_pitch  = c.pitch;
                r.note_level  = prod[15:8];
              end
            end
          end
        end
      end
      REQ_START: begin
        if (!running_q) begin
          running_q   = 1'b1;
          have_step_q = 1'b0;
          step_q      = '0;
          position_q  = '0;
        end
      end
      REQ_STOP: begin
        if (running_q) begin
          running_q     = 1'b0;
          have_step_q   = 1'b0;
          step_q        = '0;
          position_q    = '0;
          r.release_all = 1'b1;
        end
      end
      REQ_RECORD: begin
        if (running_q && have_step_q && step_q < steps_in_use()) begin
          pattern_q[step_q] = '{active: 1'b1, pitch: pitch, velocity: vel};
        end
      end
      REQ_CELL: begin
        if (slot < STEP_DEPTH) begin
          pattern_q[slot] = '{active: act, pitch: pitch, velocity: vel};
        end
      end
      default: ;
    endcase
    r.step_now   = have_step_q ? step_q : '0;
    r.step_valid = have_step_q;
    r.is_playing = running_q;
  endtask

  task automatic check_field(input string what, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      mismatch_count_o++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q       = SpsReset;
      swing_q     = SwingReset;
      len_q       = LenReset;
      loop_q      = LoopReset;
      gain_q      = GainReset;
      running_q   = 1'b0;
      have_step_q = 1'b0;
      step_q      = '0;
      position_q  = '0;
      foreach (pattern_q[i]) pattern_q[i] = '0;
      due_reports.delete();
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPS:   sps_q   = cfg_wdata_i[SpsW-1:0];
          CFG_SWING: swing_q = cfg_wdata_i[SwingW-1:0];
          CFG_LEN:   len_q   = cfg_wdata_i[LenW-1:0];
          CFG_LOOP:  loop_q  = cfg_wdata_i[0];
          CFG_GAIN:  gain_q  = cfg_wdata_i[GainW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{note_start_i, note_pitch_i, note_level_i, release_all_i,
                 step_now_i, step_valid_i, is_playing_i, reached_end_i};
        if (due_reports.size() == 0) begin
          mismatch_count_o++;
          $display("%0t ns: result item expected none, got %h", $time, seen);
        end else begin
          want = due_reports.pop_front();
          check_field("note_start", want.note_start, seen.note_start);
          check_field("note_pitch", want.note_pitch, seen.note_pitch);
          check_field("note_level", want.note_level, seen.note_level);
          check_field("release_all", want.release_all, seen.release_all);
          check_field("step_now", want.step_now, seen.step_now);
          check_field("step_valid", want.step_valid, seen.step_valid);
          check_field("is_playing", want.is_playing, seen.is_playing);
          check_field("reached_end", want.reached_end, seen.reached_end);
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_transport(req_type_i, sample_count_i, cell_index_i, pitch_i,
                          velocity_i, cell_active_i, want);
        due_reports = {due_reports, want};
        if (want.note_start) notes_o++;
        if (want.reached_end) ends_o++;
      end
      pending_o = due_reports.size();
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing step sequencer testbench
// Drives transport items into the sequencer under a series of register
// settings, with random gaps on the sending side and random stalls on the
// receiving side; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ssq_pkg::*;

  // Generous bound on the whole run. The slowest correct run is set by the
  // longest gaps and stalls on every item, plus the pattern clearing sweep
  // after reset and the pauses between settings.
  localparam int unsigned CycleLimit = 100000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         req_type_i;
  logic [CountW-1:0]  sample_count_i;
  logic [CellW-1:0]   cell_index_i;
  logic [NoteW-1:0]   pitch_i;
  logic [NoteW-1:0]   velocity_i;
  logic               cell_active_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               note_start_o;
  logic [NoteW-1:0]   note_pitch_o;
  logic [LevelW-1:0]  note_level_o;
  logic               release_all_o;
  logic [CellW-1:0]   step_now_o;
  logic               step_valid_o;
  logic               is_playing_o;
  logic               reached_end_o;

  int                 mismatches;
  int                 pending;
  int                 checked;
  int                 notes_fired;
  int                 pattern_ends;

  // When quiet is set, neither side inserts any idle cycles, so the block
  // also sees long back-to-back stretches.
  bit                 quiet;
  int unsigned        cur_sps;
  int unsigned        rx_wait;
  int unsigned        cycle_count;
  int unsigned        items_sent;
  int unsigned        settings_used;
  int unsigned        phase_sps;
  int unsigned        phase_swing;
  int unsigned        phase_len;
  int unsigned        phase_loop;
  int unsigned        phase_gain;
  int unsigned        phase_items;

  swing_step_sequencer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .sample_count_i (sample_count_i),
    .cell_index_i   (cell_index_i),
    .pitch_i        (pitch_i),
    .velocity_i     (velocity_i),
    .cell_active_i  (cell_active_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .note_start_o   (note_start_o),
    .note_pitch_o   (note_pitch_o),
    .note_level_o   (note_level_o),
    .release_all_o  (release_all_o),
    .step_now_o     (step_now_o),
    .step_valid_o   (step_valid_o),
    .is_playing_o   (is_playing_o),
    .reached_end_o  (reached_end_o)
  );

  ssq_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .sample_count_i   (sample_count_i),
    .cell_index_i     (cell_index_i),
    .pitch_i          (pitch_i),
    .velocity_i       (velocity_i),
    .cell_active_i    (cell_active_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .note_start_i     (note_start_o),
    .note_pitch_i     (note_pitch_o),
    .note_level_i     (note_level_o),
    .release_all_i    (release_all_o),
    .step_now_i       (step_now_o),
    .step_valid_i     (step_valid_o),
    .is_playing_i     (is_playing_o),
    .reached_end_i    (reached_end_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .notes_o          (notes_fired),
    .ends_o           (pattern_ends)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiving side. After each accepted result it draws a random stall, none
  // when quiet is set, and holds ready low for that long before taking the next one.
  initial begin
    out_ready_i = 1'b0;
    rx_wait     = 0;
    forever begin
      @(negedge clk_i);
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) rx_wait = quiet ? 0 : $urandom_range(0, 5);
    end
  end

  // One register write; bits above the register's width get random junk,
  // which the block is expected to drop. Called and returns at a falling edge.
  task automatic write_reg(input cfg_idx_e idx, input int unsigned value,
                           input int unsigned width);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgW'(($urandom() << width) | value);
    @(negedge clk_i);
  endtask

  // Registers change only while the block is idle: hold the sender off until
  // every predicted result has come back, then let the pipeline settle. This
  // is also the pause in which the sender waits for the receiver to catch up
  // completely.
  task automatic program_settings(input int unsigned sps, input int unsigned swing,
                                  input int unsigned len, input int unsigned loop_on,
                                  input int unsigned gain);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(CFG_SPS, sps, SpsW);
    write_reg(CFG_SWING, swing, SwingW);
    write_reg(CFG_LEN, len, LenW);
    write_reg(CFG_LOOP, loop_on, 1);
    write_reg(CFG_GAIN, gain, GainW);
    cfg_we_i <= 1'b0;
    cur_sps = sps;
    settings_used++;
  endtask

  // Sends one item: an optional gap with valid low, then valid high with a
  // fixed payload until the block takes it. Entered and left at a falling
  // edge, so valid stays high across back-to-back items without a glitch.
  task automatic send_item(input logic [2:0] req, input int unsigned count,
                           input int unsigned slot, input int unsigned pitch,
                           input int unsigned vel, input logic act);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    sample_count_i <= CountW'(count);
    cell_index_i   <= CellW'(slot);
    pitch_i        <= NoteW'(pitch);
    velocity_i     <= NoteW'(vel);
    cell_active_i  <= act;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Note numbers and velocities lean toward their extremes now and then.
  function automatic int unsigned note_value();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 127;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  // Elapsed samples for a tick. Mostly up to about two steps' worth so that
  // steps advance often, with the edges of the field mixed in.
  function automatic int unsigned tick_samples();
    int unsigned span;
    case ($urandom_range(0, 15))
      0: return 0;
      1: return 8192;
      2: return 16383;
      3: return $urandom_range(0, 16383);
      default: begin
        span = $urandom_range(0, 2 * cur_sps + 2);
        return (span > 8192) ? 8192 : span;
      end
    endcase
  endfunction

  // A random item. Ticks dominate, so the transport walks through many steps;
  // the rest start and stop playback, write cells and record notes, with a
  // few unknown request codes. Unused fields carry random values too.
  task automatic random_item();
    int unsigned pick;
    int unsigned slot;
    int unsigned pitch;
    int unsigned vel;
    logic        act;
    logic [2:0]  req;
    pick  = $urandom_range(0, 99);
    slot  = $urandom_range(0, 63);
    pitch = note_value();
    vel   = note_value();
    act   = 1'($urandom_range(0, 1));
    if (pick < 52) req = REQ_TICK;
    else if (pick < 66) req = REQ_CELL;
    else if (pick < 78) req = REQ_RECORD;
    else if (pick < 88) req = REQ_START;
    else if (pick < 94) req = REQ_STOP;
    else req = 3'($urandom_range(5, 7));
    send_item(req, tick_samples(), slot, pitch, vel, act);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SPS;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_TICK;
    sample_count_i = '0;
    cell_index_i   = '0;
    pitch_i        = '0;
    velocity_i     = '0;
    cell_active_i  = 1'b0;
    quiet          = 1'b0;
    cur_sps        = 5512;
    items_sent     = 0;
    settings_used  = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk: four-sample steps, swing of one half, a three-step
    // pattern that stops at its end, and a gain above two that must saturate.
    program_settings(4, 128, 3, 0, 1023);
    send_item(REQ_TICK, 8192, 0, 0, 0, 1'b0);         // tick while stopped
    send_item(REQ_RECORD, 0, 0, 64, 64, 1'b0);        // record while stopped
    send_item(REQ_STOP, 0, 0, 0, 0, 1'b0);            // stop while stopped
    send_item(REQ_CELL, 0, 0, 127, 127, 1'b1);        // loudest, highest note
    send_item(REQ_CELL, 0, 1, 0, 0, 1'b1);            // active but silent
    send_item(REQ_CELL, 0, 2, 127, 127, 1'b0);        // inactive step
    send_item(REQ_CELL, 0, 63, 85, 42, 1'b1);         // last entry of the store
    send_item(REQ_START, 0, 0, 0, 0, 1'b0);
    send_item(REQ_START, 0, 0, 0, 0, 1'b0);           // start while running
    send_item(REQ_RECORD, 0, 0, 1, 1, 1'b0);          // no step entered yet
    send_item(REQ_TICK, 3, 0, 0, 0, 1'b0);            // short of the first step
    send_item(REQ_TICK, 1, 0, 0, 0, 1'b0);            // enters step 0, no swing
    send_item(REQ_RECORD, 0, 0, 60, 100, 1'b0);       // overwrites step 0
    send_item(REQ_TICK, 4, 0, 0, 0, 1'b0);            // enters odd step 1
    send_item(REQ_TICK, 4, 0, 0, 0, 1'b0);            // swing holds step 1
    send_item(REQ_TICK, 1, 0, 0, 0, 1'b0);            // enters inactive step 2
    send_item(REQ_TICK, 16383, 0, 0, 0, 1'b0);        // end of pattern, stops
    send_item(3'd5, 100, 5, 5, 5, 1'b1);              // unknown request codes
    send_item(3'd6, 200, 6, 6, 6, 1'b0);
    send_item(3'd7, 16383, 63, 127, 127, 1'b1);
    send_item(REQ_START, 0, 0, 0, 0, 1'b0);
    send_item(REQ_TICK, 8192, 0, 0, 0, 1'b0);         // fires the recorded note
    send_item(REQ_STOP, 0, 0, 0, 0, 1'b0);            // stop while running

    // Random part, one register setting per phase. The first phases pin the
    // extremes: zero samples per step, a pattern length of zero and one far
    // beyond the store, zero and saturating gain, the largest step size.
    for (int phase = 0; phase < 12; phase++) begin
      phase_items = 90;
      case (phase)
        0: begin
          phase_sps = 0; phase_swing = 255; phase_len = 1; phase_loop = 1; phase_gain = 0;
        end
        1: begin
          phase_sps = 1; phase_swing = 0; phase_len = 64; phase_loop = 1; phase_gain = 512;
        end
        2: begin
          phase_sps = 3; phase_swing = 255; phase_len = 5; phase_loop = 0; phase_gain = 1023;
        end
        3: begin
          phase_sps = 7; phase_swing = 128; phase_len = 0; phase_loop = 0; phase_gain = 300;
        end
        4: begin
          phase_sps = 2; phase_swing = 200; phase_len = 127; phase_loop = 1; phase_gain = 256;
        end
        5: begin
          phase_sps = 16777215; phase_swing = 255; phase_len = 2; phase_loop = 1;
          phase_gain = 511; phase_items = 40;
        end
        default: begin
          phase_sps   = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 6000)
                                                    : $urandom_range(0, 40);
          phase_swing = $urandom_range(0, 255);
          phase_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127)
                                                    : $urandom_range(0, 64);
          phase_loop  = $urandom_range(0, 1);
          phase_gain  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 512)
                                                    : $urandom_range(0, 1023);
        end
      endcase
      program_settings(phase_sps, phase_swing, phase_len, phase_loop, phase_gain);
      // Some phases run with no idle cycles on either side at all.
      quiet = (phase == 3) || ($urandom_range(0, 4) == 0);
      repeat (phase_items) random_item();
    end

    // Wind down: wait for the last results, then let the clock run on in case
    // anything unexpected is still on its way out of the pipeline.
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d items under %0d register settings; %0d results checked.",
             items_sent, settings_used, checked);
    $display("Notes fired: %0d; patterns run to their end with looping off: %0d.",
             notes_fired, pattern_ends);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", mismatches, pending);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ssq_pkg.sv
rtl/ssq_ram.sv
rtl/swing_step_sequencer.sv
bench/ssq_checker.sv
bench/testbench.sv
